// ===== design/tfu8_pkg.sv =====
// tfu8_pkg: shared types and constants of the text frame to utf-8 transcoder
// depends on nothing; imported by every design file of the block
package tfu8_pkg;

   // configuration and count widths
   localparam int CapWidth    = 10;
   localparam int ResMax      = 4;
   localparam int ResCntWidth = 3;
   localparam logic [CapWidth-1:0] CapReset = 10'd63;

   // encoding codes carried by the first byte of a frame
   localparam logic [7:0] EncLatin1   = 8'd0;
   localparam logic [7:0] EncUtf16Bom = 8'd1;
   localparam logic [7:0] EncUtf16Be  = 8'd2;
   localparam logic [7:0] EncUtf8     = 8'd3;

   // byte order mark bytes for big-endian utf-16
   localparam logic [7:0] BomHigh = 8'hFE;
   localparam logic [7:0] BomLow  = 8'hFF;

   // one input transfer
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_first;
      logic       frame_last;
   } req_type;

   // one result transfer
   typedef struct packed {
      logic [7:0] out_byte;
      logic       string_end;
      logic       status;
   } rsp_type;

   // results produced by one input item, item[0] goes out first
   typedef struct packed {
      rsp_type [ResMax-1:0]   item;
      logic [ResCntWidth-1:0] count;
   } batch_type;

   // frame decoder phase
   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_LATIN1  = 7'b0000010,
      PH_UTF8    = 7'b0000100,
      PH_MARK_A  = 7'b0001000,
      PH_MARK_B  = 7'b0010000,
      PH_BODY    = 7'b0100000,
      PH_UNKNOWN = 7'b1000000
   } phase_type;

endpackage

// ===== design/tfu8_conv.sv =====
// tfu8_conv: frame state registers and the single-pass byte to utf-8 conversion
// depends on tfu8_pkg
module tfu8_conv
   import tfu8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                item_fire,
   input  req_type             item,
   input  logic [CapWidth-1:0] capacity,
   output batch_type           batch
);

   phase_type           phase_ff, phase_in;
   logic                le_ff, le_in;
   logic [7:0]          held_ff, held_in;
   logic                have_ff, have_in;
   logic [CapWidth-1:0] cnt_ff, cnt_in;
   logic                halt_ff, halt_in;

   logic [CapWidth-1:0] room;
   logic                room_one, room_two, room_three;
   logic [15:0]         unit;
   logic [2:0][7:0]     text;
   logic [1:0]          ntext;
   logic [7:0]          b;
   rsp_type             term;

   // room left under the capacity and the assembled utf-16 unit
   always_comb begin
      b          = item.data_byte;
      room       = (cnt_ff < capacity) ? (capacity - cnt_ff) : '0;
      room_one   = (room != '0);
      room_two   = (room >= CapWidth'(2));
      room_three = (room >= CapWidth'(3));
      unit       = le_ff ? {b, held_ff} : {held_ff, b};
   end

   // next state and text bytes for the item
   always_comb begin
      phase_in = phase_ff;
      le_in    = le_ff;
      held_in  = held_ff;
      have_in  = have_ff;
      halt_in  = halt_ff;
      text     = '0;
      ntext    = 2'd0;
      if (item.frame_first) begin
         halt_in = 1'b0;
         have_in = 1'b0;
         held_in = 8'd0;
         le_in   = 1'b1;
         if (b == EncLatin1) begin
            phase_in = PH_LATIN1;
         end else if (b == EncUtf8) begin
            phase_in = PH_UTF8;
         end else if (b == EncUtf16Bom) begin
            phase_in = PH_MARK_A;
         end else if (b == EncUtf16Be) begin
            phase_in = PH_BODY;
            le_in    = 1'b0;
         end else begin
            phase_in = PH_UNKNOWN;
         end
      end else begin
         case (phase_ff)
            PH_LATIN1: begin
               if (!halt_ff && room_one) begin
                  if (!b[7]) begin
                     text[0] = b;
                     ntext   = 2'd1;
                  end else if (room_two) begin
                     text[0] = {6'b110000, b[7:6]};
                     text[1] = {2'b10, b[5:0]};
                     ntext   = 2'd2;
                  end else begin
                     halt_in = 1'b1;
                  end
               end
            end
            PH_UTF8: begin
               if (room_one) begin
                  text[0] = b;
                  ntext   = 2'd1;
               end
            end
            PH_MARK_A: begin
               held_in  = b;
               phase_in = PH_MARK_B;
            end
            PH_MARK_B: begin
               le_in    = !(held_ff == BomHigh && b == BomLow);
               held_in  = 8'd0;
               phase_in = PH_BODY;
            end
            PH_BODY: begin
               if (!have_ff) begin
                  held_in = b;
                  have_in = 1'b1;
               end else begin
                  have_in = 1'b0;
                  if (!halt_ff && room_one) begin
                     if (unit == 16'd0) begin
                        halt_in = 1'b1;
                     end else if (unit < 16'h0080) begin
                        text[0] = unit[7:0];
                        ntext   = 2'd1;
                     end else if (unit < 16'h0800) begin
                        if (room_two) begin
                           text[0] = {3'b110, unit[10:6]};
                           text[1] = {2'b10, unit[5:0]};
                           ntext   = 2'd2;
                        end
                     end else if (room_three) begin
                        text[0] = {4'b1110, unit[15:12]};
                        text[1] = {2'b10, unit[11:6]};
                        text[2] = {2'b10, unit[5:0]};
                        ntext   = 2'd3;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      // terminator closes the frame
      if (item.frame_last && phase_in != PH_IDLE) begin
         phase_in = PH_IDLE;
         have_in  = 1'b0;
      end
      cnt_in = item.frame_first ? '0 : (cnt_ff + CapWidth'(ntext));
   end

   // a byte outside a frame gives no result, its last flag included
   always_comb begin
      logic term_on;
      term_on         = item.frame_last && (item.frame_first || phase_ff != PH_IDLE);
      term.out_byte   = 8'd0;
      term.string_end = 1'b1;
      term.status     = item.frame_first ? !(b == EncLatin1 || b == EncUtf8 ||
                                             b == EncUtf16Bom || b == EncUtf16Be)
                                         : (phase_ff == PH_UNKNOWN);
      batch.item[0] = (ntext > 2'd0) ? '{out_byte: text[0], string_end: 1'b0, status: 1'b0}
                                     : term;
      batch.item[1] = (ntext > 2'd1) ? '{out_byte: text[1], string_end: 1'b0, status: 1'b0}
                                     : term;
      batch.item[2] = (ntext > 2'd2) ? '{out_byte: text[2], string_end: 1'b0, status: 1'b0}
                                     : term;
      batch.item[3] = term;
      batch.count   = ResCntWidth'(ntext) + ResCntWidth'(term_on);
   end

   // state registers advance once per consumed item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         le_ff    <= 1'b1;
         held_ff  <= 8'd0;
         have_ff  <= 1'b0;
         cnt_ff   <= '0;
         halt_ff  <= 1'b0;
      end else if (item_fire) begin
         phase_ff <= phase_in;
         le_ff    <= le_in;
         held_ff  <= held_in;
         have_ff  <= have_in;
         cnt_ff   <= cnt_in;
         halt_ff  <= halt_in;
      end
   end

endmodule

// ===== design/tfu8_rspq.sv =====
// tfu8_rspq: result register holding the results of one item, drained one per transfer
// depends on tfu8_pkg
module tfu8_rspq
   import tfu8_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  batch_type batch,
   output logic      free,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   rsp_type [ResMax-1:0]   slot_ff, slot_in;
   logic [ResCntWidth-1:0] rem_ff, rem_in;
   logic                   pop;

   // handshake and free flag for the next batch
   assign rsp_valid = (rem_ff != '0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (rem_ff == '0) || (rem_ff == ResCntWidth'(1) && rsp_ready);

   // load a new batch or shift the next result to the head
   always_comb begin
      slot_in = slot_ff;
      rem_in  = rem_ff;
      if (load) begin
         slot_in = batch.item;
         rem_in  = batch.count;
      end else if (pop) begin
         for (int k = 0; k < ResMax - 1; k++) begin
            slot_in[k] = slot_ff[k+1];
         end
         rem_in = rem_ff - ResCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// ===== design/text_frame_to_utf8_transcoder_top.sv =====
// text_frame_to_utf8_transcoder_top: input register, converter and result register
// depends on tfu8_pkg, tfu8_conv, tfu8_rspq
//
// Usage
//   req_* carries frame bytes (valid/ready); the frame_first byte is the encoding
//   code, frame_last closes the frame with a zero terminator result.
//   rsp_* carries utf-8 text bytes and the terminator (valid/ready).
//   csr_wr_en/csr_wr_data write the capacity, the most text bytes per frame;
//   write it only while no frame byte is in flight.
// Path: an item passes the input register, the converter and the result register,
//   so its first result is registered; a full result register holds the item back.
// Throughput: an item yields 0 to 4 results; the result register sends one result
//   a cycle while rsp_ready is high and takes the next item in the cycle its last
//   result leaves, so single-byte text streams at one byte a cycle.
// Reset: synchronous; clears the frame state, empties both registers and sets the
//   capacity to 63.
// Stall: while rsp_ready is low the held result stays put, the input register
//   keeps its byte and req_ready falls once it is full.
module text_frame_to_utf8_transcoder_top
   import tfu8_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [CapWidth-1:0] csr_wr_data
);

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff;
   logic [CapWidth-1:0] cap_ff;
   logic                buf_free;
   logic                in_fire;
   batch_type           batch;

   // input register handshake
   assign in_fire   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || buf_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (in_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   tfu8_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .item_fire (in_fire),
      .item      (in_data_ff),
      .capacity  (cap_ff),
      .batch     (batch)
   );

   tfu8_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire),
      .batch     (batch),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/tfu8_checker.sv =====
// tfu8_checker: port-level assertions on the transcoder, bound to the top level
// depends on tfu8_pkg and text_frame_to_utf8_transcoder_top
module tfu8_checker
   import tfu8_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // nothing leaves right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the terminator carries a zero byte
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.string_end |-> rsp_data.out_byte == 8'd0)
      else $error("terminator with nonzero byte");

   // text bytes carry status zero
   a_text_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.string_end |-> !rsp_data.status)
      else $error("text byte with status set");

endmodule

bind text_frame_to_utf8_transcoder_top tfu8_checker u_tfu8_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/testbench.sv =====
// testbench: self-checking bench for text_frame_to_utf8_transcoder_top
// depends on tfu8_pkg and the transcoder rtl; a scripted set of frames, then random frames,
// compared against typed results in the script or else an in-bench utf-8 predictor
`timescale 1ns / 100ps

module testbench
   import tfu8_pkg::*;
;

   localparam int RandomItems   = 320;
   localparam int PhaseItems    = 40;
   localparam int QuietTail     = 40;
   localparam int SettleCycles  = 8;
   localparam int DrainLimit    = 4000;
   localparam int PrintLimit    = 40;
   localparam int RunLimitNs    = 2_000_000;
   localparam logic [15:0] OneByteLimit = 16'h0080;
   localparam logic [15:0] TwoByteLimit = 16'h0800;

   typedef enum logic [1:0] {
      ROW_BYTE,
      ROW_CAPACITY
   } row_kind_type;

   // one line of the scripted part; typed_n < 0 leaves the result to the predictor
   typedef struct packed {
      row_kind_type          kind;
      req_type               item;
      logic [CapWidth-1:0]   cap;
      int                    typed_n;
      rsp_type [ResMax-1:0]  typed;
   } script_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_data;
   logic                csr_wr_en;
   logic [CapWidth-1:0] csr_wr_data;

   // predictor copy of the decoder state and the capacity register
   phase_type           dec_phase;
   logic                dec_little;
   logic [7:0]          dec_held;
   logic                dec_have_held;
   logic [CapWidth-1:0] dec_written;
   logic                dec_halted;
   logic [CapWidth-1:0] cap_setting;

   rsp_type        utf8_out_q [$];
   script_row_type script_q [$];

   bit idling_on;
   int mismatch_count;
   int frame_bytes_sent;
   int frames_opened;
   int cap_writes;
   int text_bytes_checked;
   int terminators_seen;

   text_frame_to_utf8_transcoder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin : watchdog
      #(RunLimitNs);
      $display("timeout at %0t with %0d results outstanding", $time, utf8_out_q.size());
      $display("DONE: errors detected");
      $finish;
   end

   function automatic req_type make_req(input logic [7:0] b, input logic f, input logic l);
      req_type r;
      r.data_byte   = b;
      r.frame_first = f;
      r.frame_last  = l;
      return r;
   endfunction

   function automatic rsp_type text_res(input logic [7:0] b);
      rsp_type r;
      r.out_byte   = b;
      r.string_end = 1'b0;
      r.status     = 1'b0;
      return r;
   endfunction

   function automatic rsp_type term_res(input logic st);
      rsp_type r;
      r.out_byte   = 8'h00;
      r.string_end = 1'b1;
      r.status     = st;
      return r;
   endfunction

   // utf-8 prediction for one accepted frame byte; updates the decoder state
   function automatic int transcode_byte(input req_type item,
                                         output rsp_type [ResMax-1:0] res);
      int                  n;
      int                  seq_n;
      logic [7:0]          seq [3];
      logic [7:0]          b;
      logic [CapWidth-1:0] room;
      logic [15:0]         code_unit;
      n         = 0;
      seq_n     = 0;
      res       = '0;
      b         = item.data_byte;
      room      = (dec_written < cap_setting) ? cap_setting - dec_written : '0;
      code_unit = '0;
      if (item.frame_first) begin
         // encoding byte opens a fresh frame, dropping any open one
         dec_written   = '0;
         dec_halted    = 1'b0;
         dec_have_held = 1'b0;
         dec_held      = '0;
         dec_little    = 1'b1;
         case (b)
            EncLatin1:   dec_phase = PH_LATIN1;
            EncUtf8:     dec_phase = PH_UTF8;
            EncUtf16Bom: dec_phase = PH_MARK_A;
            EncUtf16Be: begin
               dec_phase  = PH_BODY;
               dec_little = 1'b0;
            end
            default:     dec_phase = PH_UNKNOWN;
         endcase
      end else if (dec_phase == PH_IDLE) begin
         return 0;
      end else begin
         case (dec_phase)
            PH_LATIN1: begin
               // widen to one or two bytes, halt if a two-byte char has no room
               if (!dec_halted && room != 0) begin
                  if (!b[7]) begin
                     seq[0] = b;
                     seq_n  = 1;
                  end else if (room >= 2) begin
                     seq[0] = {6'b110000, b[7:6]};
                     seq[1] = {2'b10, b[5:0]};
                     seq_n  = 2;
                  end else begin
                     dec_halted = 1'b1;
                  end
               end
            end
            PH_UTF8: begin
               if (room != 0) begin
                  seq[0] = b;
                  seq_n  = 1;
               end
            end
            PH_MARK_A: begin
               dec_held  = b;
               dec_phase = PH_MARK_B;
            end
            PH_MARK_B: begin
               dec_little = !(dec_held == BomHigh && b == BomLow);
               dec_held   = '0;
               dec_phase  = PH_BODY;
            end
            PH_BODY: begin
               // pair bytes into a code unit, then encode it whole or drop it
               if (!dec_have_held) begin
                  dec_held      = b;
                  dec_have_held = 1'b1;
               end else begin
                  code_unit     = dec_little ? {b, dec_held} : {dec_held, b};
                  dec_have_held = 1'b0;
                  if (!dec_halted && room != 0) begin
                     if (code_unit == 16'h0000) begin
                        dec_halted = 1'b1;
                     end else if (code_unit < OneByteLimit) begin
                        seq[0] = code_unit[7:0];
                        seq_n  = 1;
                     end else if (code_unit < TwoByteLimit) begin
                        if (room >= 2) begin
                           seq[0] = {3'b110, code_unit[10:6]};
                           seq[1] = {2'b10, code_unit[5:0]};
                           seq_n  = 2;
                        end
                     end else if (room >= 3) begin
                        seq[0] = {4'b1110, code_unit[15:12]};
                        seq[1] = {2'b10, code_unit[11:6]};
                        seq[2] = {2'b10, code_unit[5:0]};
                        seq_n  = 3;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      for (int i = 0; i < seq_n; i++) begin
         res[n]      = text_res(seq[i]);
         n++;
         dec_written = dec_written + 1'b1;
      end
      // terminator closes the frame
      if (item.frame_last) begin
         res[n]        = term_res(dec_phase == PH_UNKNOWN);
         n++;
         dec_phase     = PH_IDLE;
         dec_have_held = 1'b0;
      end
      return n;
   endfunction

   function automatic void push_results(input int n, input rsp_type [ResMax-1:0] res);
      for (int i = 0; i < n; i++) utf8_out_q.push_back(res[i]);
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic f, input logic l);
      script_row_type row;
      row         = '0;
      row.kind    = ROW_BYTE;
      row.item    = make_req(b, f, l);
      row.typed_n = -1;
      script_q.push_back(row);
   endfunction

   function automatic void add_typed(input logic [7:0] b, input logic f, input logic l,
                                     input int n, input rsp_type r0, input rsp_type r1,
                                     input rsp_type r2);
      script_row_type row;
      row          = '0;
      row.kind     = ROW_BYTE;
      row.item     = make_req(b, f, l);
      row.typed_n  = n;
      row.typed[0] = r0;
      row.typed[1] = r1;
      row.typed[2] = r2;
      script_q.push_back(row);
   endfunction

   function automatic void add_capacity(input logic [CapWidth-1:0] value);
      script_row_type row;
      row      = '0;
      row.kind = ROW_CAPACITY;
      row.cap  = value;
      script_q.push_back(row);
   endfunction

   function automatic void note_mismatch(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (mismatch_count < PrintLimit)
         $display("%0t: %s expected %h got %h", $time, field, want, got);
      mismatch_count++;
   endfunction

   // drive one frame byte and hold it until the transfer, then predict
   task automatic send_frame_byte(input req_type item, output int n,
                                  output rsp_type [ResMax-1:0] res);
      int gap;
      if (idling_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.frame_first || dec_phase != PH_IDLE) frame_bytes_sent++;
      if (item.frame_first) frames_opened++;
      n = transcode_byte(item, res);
   endtask

   // capacity changes only once the block has drained
   task automatic write_capacity(input logic [CapWidth-1:0] value);
      req_valid <= 1'b0;
      while (utf8_out_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_setting = value;
      cap_writes++;
   endtask

   // random frame: mostly well-formed text in a known encoding
   task automatic send_random_frame();
      logic [7:0]           body [$];
      logic [7:0]           enc;
      logic [7:0]           mark0;
      logic [7:0]           mark1;
      logic [15:0]          code_unit;
      bit                   lsb_first;
      bit                   close;
      int                   pick;
      int                   units;
      int                   keep;
      int                   n;
      rsp_type [ResMax-1:0] res;
      lsb_first = 1'b0;
      // stray bytes, outside a frame when the last one was closed
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 2)) begin
            send_frame_byte(make_req(8'($urandom_range(0, 255)), 1'b0,
                                     1'($urandom_range(0, 1))), n, res);
            push_results(n, res);
         end
      end
      pick = $urandom_range(0, 99);
      if (pick < 22)      enc = EncLatin1;
      else if (pick < 40) enc = EncUtf8;
      else if (pick < 65) enc = EncUtf16Bom;
      else if (pick < 92) enc = EncUtf16Be;
      else                enc = 8'($urandom_range(4, 255));
      units = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
      if (enc == EncUtf16Bom) begin
         case ($urandom_range(0, 3))
            0, 1: begin
               mark0 = BomHigh;
               mark1 = BomLow;
            end
            2: begin
               mark0 = BomLow;
               mark1 = BomHigh;
            end
            default: begin
               mark0 = 8'($urandom_range(0, 255));
               mark1 = 8'($urandom_range(0, 255));
            end
         endcase
         lsb_first = !(mark0 == BomHigh && mark1 == BomLow);
         body.push_back(mark0);
         body.push_back(mark1);
      end
      for (int i = 0; i < units; i++) begin
         if (enc == EncUtf16Bom || enc == EncUtf16Be) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)      code_unit = 16'($urandom_range(16'h0001, 16'h007F));
            else if (pick < 55) code_unit = 16'($urandom_range(16'h0080, 16'h07FF));
            else if (pick < 75) code_unit = 16'($urandom_range(16'h0800, 16'hFFFF));
            else if (pick < 85) code_unit = 16'($urandom_range(16'hD800, 16'hDFFF));
            else if (pick < 90) code_unit = 16'h0000;
            else                code_unit = 16'($urandom_range(0, 16'hFFFF));
            if (lsb_first) begin
               body.push_back(code_unit[7:0]);
               body.push_back(code_unit[15:8]);
            end else begin
               body.push_back(code_unit[15:8]);
               body.push_back(code_unit[7:0]);
            end
         end else begin
            body.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E))
                                                : 8'($urandom_range(0, 255)));
         end
      end
      // odd trailing byte, or a frame cut short anywhere
      if ((enc == EncUtf16Bom || enc == EncUtf16Be) && $urandom_range(0, 3) == 0)
         body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 15) == 0) begin
         keep = $urandom_range(0, body.size());
         while (body.size() > keep) void'(body.pop_back());
      end
      // a few frames are left open and get abandoned by the next one
      close = ($urandom_range(0, 11) != 0);
      send_frame_byte(make_req(enc, 1'b1, close && body.size() == 0), n, res);
      push_results(n, res);
      foreach (body[i]) begin
         send_frame_byte(make_req(body[i], 1'b0, close && i == body.size() - 1), n, res);
         push_results(n, res);
      end
   endtask

   // result side stalls in random bursts
   initial begin : rsp_backpressure
      int hold;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (idling_on && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (utf8_out_q.size() == 0) begin
            note_mismatch("unexpected result out_byte", 8'h00, rsp_data.out_byte);
         end else begin
            want = utf8_out_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               note_mismatch("out_byte", want.out_byte, rsp_data.out_byte);
            if (rsp_data.string_end !== want.string_end)
               note_mismatch("string_end", 8'(want.string_end), 8'(rsp_data.string_end));
            if (rsp_data.status !== want.status)
               note_mismatch("status", 8'(want.status), 8'(rsp_data.status));
            if (want.string_end) terminators_seen++;
            else text_bytes_checked++;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int                   n;
      int                   random_start;
      int                   phase_end;
      int                   phase_idx;
      int                   drain_cycles;
      logic [CapWidth-1:0]  next_cap;
      rsp_type [ResMax-1:0] res;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      idling_on        = 1'b0;
      mismatch_count   = 0;
      frame_bytes_sent = 0;
      frames_opened    = 0;
      cap_writes       = 0;
      dec_phase        = PH_IDLE;
      dec_little       = 1'b1;
      dec_held         = '0;
      dec_have_held    = 1'b0;
      dec_written      = '0;
      dec_halted       = 1'b0;
      cap_setting      = CapReset;

      // byte with no open frame is dropped, its frame_last too
      add_typed(8'h41, 1'b0, 1'b1, 0, '0, '0, '0);
      // latin-1, top byte widens to two
      add_row(EncLatin1, 1'b1, 1'b0);
      add_typed(8'hFF, 1'b0, 1'b1, 3, text_res(8'hC3), text_res(8'hBF), term_res(1'b0));
      // utf-8 copy, left open
      add_row(EncUtf8, 1'b1, 1'b0);
      add_row(8'hA5, 1'b0, 1'b0);
      // new frame abandons it: big-endian mark, then a lone surrogate
      add_row(EncUtf16Bom, 1'b1, 1'b0);
      add_row(BomHigh, 1'b0, 1'b0);
      add_row(BomLow, 1'b0, 1'b0);
      add_row(8'hD8, 1'b0, 1'b0);
      add_row(8'h00, 1'b0, 1'b1);
      // big-endian with no mark, zero unit ends the text, odd byte at the end
      add_row(EncUtf16Be, 1'b1, 1'b0);
      add_row(8'h07, 1'b0, 1'b0);
      add_row(8'hFF, 1'b0, 1'b0);
      add_row(8'h00, 1'b0, 1'b0);
      add_row(8'h00, 1'b0, 1'b0);
      add_row(8'h41, 1'b0, 1'b1);
      // unknown encoding opened and closed by one byte
      add_typed(8'hFF, 1'b1, 1'b1, 1, term_res(1'b1), '0, '0);
      // frame closes inside the byte order mark
      add_row(EncUtf16Bom, 1'b1, 1'b0);
      add_typed(BomHigh, 1'b0, 1'b1, 1, term_res(1'b0), '0, '0);
      // latin-1 halts when a two-byte char meets one byte of room
      add_capacity(10'd1);
      add_row(EncLatin1, 1'b1, 1'b0);
      add_row(8'hE9, 1'b0, 1'b0);
      add_row(8'h41, 1'b0, 1'b1);
      // oversized unit dropped, capacity lowered mid-frame, then full
      add_capacity(10'd2);
      add_row(EncUtf16Be, 1'b1, 1'b0);
      add_row(8'h08, 1'b0, 1'b0);
      add_row(8'h00, 1'b0, 1'b0);
      add_row(8'h00, 1'b0, 1'b0);
      add_row(8'h41, 1'b0, 1'b0);
      add_capacity(10'd1);
      add_row(8'h00, 1'b0, 1'b0);
      add_row(8'h42, 1'b0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // scripted part
      foreach (script_q[i]) begin
         if (script_q[i].kind == ROW_CAPACITY) begin
            write_capacity(script_q[i].cap);
         end else begin
            send_frame_byte(script_q[i].item, n, res);
            if (script_q[i].typed_n >= 0) push_results(script_q[i].typed_n, script_q[i].typed);
            else push_results(n, res);
         end
      end

      // random part, one capacity setting per stretch, quiet at the end
      random_start = frame_bytes_sent;
      phase_idx    = 0;
      while (frame_bytes_sent - random_start < RandomItems) begin
         case (phase_idx % 5)
            0:       next_cap = 10'd1023;
            1:       next_cap = 10'd1;
            2:       next_cap = CapWidth'($urandom_range(2, 8));
            3:       next_cap = CapWidth'($urandom_range(9, 40));
            default: next_cap = CapWidth'($urandom_range(1, 1023));
         endcase
         write_capacity(next_cap);
         phase_end = frame_bytes_sent + PhaseItems;
         while (frame_bytes_sent < phase_end &&
                frame_bytes_sent - random_start < RandomItems) begin
            idling_on = (RandomItems - (frame_bytes_sent - random_start) > QuietTail) &&
                        ($urandom_range(0, 3) != 0);
            send_random_frame();
         end
         phase_idx++;
      end

      // drain, then watch a little longer for stray results
      req_valid <= 1'b0;
      drain_cycles = 0;
      while (utf8_out_q.size() != 0 && drain_cycles < DrainLimit) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (utf8_out_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, utf8_out_q.size());
         mismatch_count += utf8_out_q.size();
      end

      $display("sent %0d frame bytes in %0d frames across %0d capacity writes",
               frame_bytes_sent, frames_opened, cap_writes);
      $display("checked %0d utf-8 bytes and %0d terminators", text_bytes_checked,
               terminators_seen);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/tfu8_pkg.sv
design/tfu8_conv.sv
design/tfu8_rspq.sv
design/text_frame_to_utf8_transcoder_top.sv
design/tfu8_checker.sv
bench/testbench.sv
